FILE: rtl/rse_pkg.sv
`timescale 1ns / 1ps

package rse_pkg;

    localparam int NUM_CHECK_DEF = 4;
    localparam int SYM_W         = 8;
    localparam int IDX_W         = 3;
    localparam int GEN_W         = 64;
    localparam int CFG_ADDR_W    = 1;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 16;

    localparam logic [SYM_W-1:0] FIELD_POLY_RST = 8'd29;
    localparam logic [GEN_W-1:0] GEN_COEFFS_RST = '0;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_POLY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GEN_COEFFS = 1'b1;

    // one data byte handed to the remainder update
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [SYM_W-1:0] data;
    } rse_step_t;

endpackage

FILE: rtl/rse_lfsr.sv
`timescale 1ns / 1ps

module rse_lfsr #(
    parameter int NUM_CHECK = rse_pkg::NUM_CHECK_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  rse_pkg::rse_step_t                        step,
    input  logic [rse_pkg::SYM_W-1:0]                 field_poly,
    input  logic [rse_pkg::GEN_W-1:0]                 gen_coeffs,
    output logic [NUM_CHECK-1:0][rse_pkg::SYM_W-1:0]  check_bytes
);
    import rse_pkg::*;

    logic [NUM_CHECK-1:0][SYM_W-1:0] rem_reg;
    logic [NUM_CHECK-1:0][SYM_W-1:0] rem_next;
    logic [NUM_CHECK-1:0][SYM_W-1:0] rem_new;

    function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] a,
                                                   input logic [SYM_W-1:0] poly);
        gf_xtime = {a[SYM_W-2:0], 1'b0} ^ (a[SYM_W-1] ? poly : '0);
    endfunction

    generate
        if (NUM_CHECK == 1) begin : g_parity
            // single check byte: plain xor of the data bytes
            assign rem_new[0] = rem_reg[0] ^ step.data;
        end else begin : g_div
            logic [SYM_W-1:0]            fb;
            logic [SYM_W-1:0][SYM_W-1:0] pw;
            logic [NUM_CHECK-1:0][SYM_W-1:0] prod;

            always_comb begin
                fb    = step.data ^ rem_reg[0];
                pw[0] = fb;
                // fb * x^j, shared by all taps
                for (int j = 1; j < SYM_W; j++) begin
                    pw[j] = gf_xtime(pw[j-1], field_poly);
                end
                for (int i = 0; i < NUM_CHECK; i++) begin
                    prod[i] = '0;
                    for (int j = 0; j < SYM_W; j++) begin
                        if (gen_coeffs[SYM_W*i + j]) begin
                            prod[i] = prod[i] ^ pw[j];
                        end
                    end
                end
                for (int i = 0; i < NUM_CHECK - 1; i++) begin
                    rem_new[i] = rem_reg[i+1] ^ prod[i];
                end
                rem_new[NUM_CHECK-1] = prod[NUM_CHECK-1];
            end
        end
    endgenerate

    assign check_bytes = rem_new;

    always_comb begin
        rem_next = rem_reg;
        if (step.valid) begin
            rem_next = step.last ? '0 : rem_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
        end else begin
            rem_reg <= rem_next;
        end
    end

endmodule

FILE: rtl/rse_unload.sv
`timescale 1ns / 1ps

module rse_unload #(
    parameter int NUM_CHECK = rse_pkg::NUM_CHECK_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      load_en,
    input  logic [NUM_CHECK-1:0][rse_pkg::SYM_W-1:0]  load_bytes,
    output logic                                      can_load,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [rse_pkg::SYM_W-1:0]                 out_symbol,
    output logic [rse_pkg::IDX_W-1:0]                 out_index,
    output logic                                      out_last
);
    import rse_pkg::*;

    localparam int CNT_W = $clog2(NUM_CHECK + 1);

    logic [NUM_CHECK-1:0][SYM_W-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            pop;

    assign out_valid  = (cnt_reg != '0);
    assign pop        = out_valid && out_ready;
    assign can_load   = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign out_symbol = buf_reg[0];
    assign out_index  = idx_reg;
    assign out_last   = (idx_reg == IDX_W'(NUM_CHECK - 1));

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load_en) begin
            buf_next = load_bytes;
            cnt_next = CNT_W'(NUM_CHECK);
            idx_next = '0;
        end else if (pop) begin
            for (int i = 0; i < NUM_CHECK - 1; i++) begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: rtl/rs_systematic_encoder.sv
`timescale 1ns / 1ps
// the last data beat is registered in the input register, then its check bytes in the output shift register
// throughput: one data beat per cycle; NUM_CHECK check beats leave the output shift
// register per codeword, one per cycle when m_tready is high, while data of the next codeword keeps flowing
// a last data beat waits in the input register while the previous check run is draining
// reset (aresetn low, synchronous): remainder cleared and output buffer emptied, field poly 29,
// generator coefficients 0
module rs_systematic_encoder #(
    parameter int NUM_CHECK = rse_pkg::NUM_CHECK_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rse_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rse_pkg::GEN_W-1:0]          cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rse_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] data_symbol
    input  logic                               s_tlast,   // last_symbol
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rse_pkg::M_TDATA_W-1:0]      m_tdata,   // [7:0] check_symbol, [10:8] check_index
    output logic                               m_tlast    // last_check
);
    import rse_pkg::*;

    logic                  in_valid_reg, in_valid_next;
    logic                  in_last_reg;
    logic [SYM_W-1:0]      in_data_reg;
    logic [SYM_W-1:0]      field_poly_reg;
    logic [GEN_W-1:0]      gen_coeffs_reg;
    logic                  s_fire;
    logic                  stall;
    logic                  can_load;
    logic                  load_en;
    rse_step_t             step;
    logic [NUM_CHECK-1:0][SYM_W-1:0] check_bytes;
    logic [SYM_W-1:0]      check_symbol;
    logic [IDX_W-1:0]      check_index;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_poly_reg <= FIELD_POLY_RST;
            gen_coeffs_reg <= GEN_COEFFS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_FIELD_POLY: field_poly_reg <= cfg_wdata[SYM_W-1:0];
                CFG_GEN_COEFFS: gen_coeffs_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // a last beat needs the output buffer free (or emptying this cycle)
    assign stall         = in_valid_reg && in_last_reg && !can_load;
    assign s_tready      = !stall;
    assign s_fire        = s_tvalid && s_tready;
    assign in_valid_next = s_fire || stall;

    assign step.valid = in_valid_reg && !stall;
    assign step.last  = in_last_reg;
    assign step.data  = in_data_reg;
    assign load_en    = step.valid && step.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_tdata[SYM_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    rse_lfsr #(
        .NUM_CHECK (NUM_CHECK)
    ) u_lfsr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .field_poly  (field_poly_reg),
        .gen_coeffs  (gen_coeffs_reg),
        .check_bytes (check_bytes)
    );

    rse_unload #(
        .NUM_CHECK (NUM_CHECK)
    ) u_unload (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_en    (load_en),
        .load_bytes (check_bytes),
        .can_load   (can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_symbol (check_symbol),
        .out_index  (check_index),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W - SYM_W - IDX_W){1'b0}}, check_index, check_symbol};

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_en |=> m_tvalid && (check_index == '0))
        else $error("check run did not start after last data beat");

    a_run_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast && !load_en |=> !m_tvalid)
        else $error("check beats continue past the last one");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> in_valid_reg && in_last_reg && $stable(in_data_reg))
        else $error("stalled last beat lost from input register");

    a_no_early_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !load_en)
        else $error("check buffer reloaded while a run is pending");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import rse_pkg::*;

    localparam int NCHK     = NUM_CHECK_DEF;
    localparam int DIR_ROWS = 23;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] index;
        logic             last;
    } check_beat_t;

    typedef enum logic {ROW_SYM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [GEN_W-1:0]       value;
        logic [SYM_W-1:0]       data;
        logic                   last;
        logic                   typed;
        logic [NCHK*SYM_W-1:0]  checks;   // first check byte in the top byte
    } row_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_ADDR_W-1:0]   cfg_addr;
    logic [GEN_W-1:0]        cfg_wdata;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;

    // encoder model state and its copy of the registers
    logic [SYM_W-1:0] rem_model [NCHK];
    logic [SYM_W-1:0] poly_model;
    logic [GEN_W-1:0] gen_model;

    check_beat_t pending_checks [$];
    int unsigned mismatches   = 0;
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    bit          hold_req     = 1'b0;

    rs_systematic_encoder #(.NUM_CHECK(NCHK)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_400_000;
        $display("tb failed");
        $finish;
    end

    function automatic logic [SYM_W-1:0] gf_times(input logic [SYM_W-1:0] a,
                                                  input logic [SYM_W-1:0] b,
                                                  input logic [SYM_W-1:0] poly);
        logic [SYM_W-1:0] acc;
        logic [SYM_W-1:0] x;
        acc = '0;
        x   = a;
        for (int k = 0; k < SYM_W; k++) begin
            if (b[k]) acc ^= x;
            x = x[SYM_W-1] ? ((x << 1) ^ poly) : (x << 1);
        end
        return acc;
    endfunction

    // shift one data byte into the division by g(x); on the last byte the
    // remainder becomes the check run and is cleared
    function automatic void absorb_symbol(input logic [SYM_W-1:0] d, input logic l,
                                          input bit queue_it);
        logic [SYM_W-1:0] fb;
        check_beat_t      beat;
        if (NCHK == 1) begin
            rem_model[0] ^= d;
        end else begin
            fb = d ^ rem_model[0];
            for (int i = 0; i < NCHK - 1; i++)
                rem_model[i] = rem_model[i + 1]
                             ^ gf_times(fb, gen_model[SYM_W*i +: SYM_W], poly_model);
            rem_model[NCHK-1] = gf_times(fb, gen_model[SYM_W*(NCHK-1) +: SYM_W], poly_model);
        end
        if (l) begin
            for (int i = 0; i < NCHK; i++) begin
                beat.symbol = rem_model[i];
                beat.index  = IDX_W'(i);
                beat.last   = (i == NCHK - 1);
                if (queue_it) pending_checks.push_back(beat);
                rem_model[i] = '0;
            end
        end
    endfunction

    function automatic row_t sym_row(input logic [SYM_W-1:0] d, input logic l,
                                     input logic typed, input logic [NCHK*SYM_W-1:0] checks);
        row_t r;
        r        = '0;
        r.kind   = ROW_SYM;
        r.data   = d;
        r.last   = l;
        r.typed  = typed;
        r.checks = checks;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_ADDR_W-1:0] addr,
                                     input logic [GEN_W-1:0] value);
        row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.value = value;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [GEN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == CFG_FIELD_POLY)
            poly_model = value[SYM_W-1:0];
        else
            gen_model = value;
        @(negedge aclk);
    endtask

    task automatic send_symbol(input logic [SYM_W-1:0] d, input logic l, input bit queue_it);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        absorb_symbol(d, l, queue_it);
        @(negedge aclk);
    endtask

    // let every check beat out and the input register empty before a register write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_checks.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_left = 80;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        check_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_checks.size() == 0) begin
                $display("%0t: check beat with nothing expected: tdata %h tlast %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = pending_checks.pop_front();
                if (m_tdata[SYM_W-1:0] !== want.symbol) begin
                    $display("%0t: check_symbol expected %h actual %h",
                             $time, want.symbol, m_tdata[SYM_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[SYM_W +: IDX_W] !== want.index) begin
                    $display("%0t: check_index expected %0d actual %0d",
                             $time, want.index, m_tdata[SYM_W +: IDX_W]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_check expected %b actual %b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        row_t             rows [DIR_ROWS];
        check_beat_t      beat;
        int unsigned      sent;
        int unsigned      cw_len;
        bit               open_end;
        logic [SYM_W-1:0] d;
        logic [SYM_W-1:0] poly_pick;
        logic [GEN_W-1:0] gen_pick;

        rows = '{
            // generator all zero after reset: every check byte is zero
            sym_row(8'h00, 1'b1, 1'b1, 32'h0000_0000),
            sym_row(8'hff, 1'b1, 1'b1, 32'h0000_0000),
            sym_row(8'ha5, 1'b0, 1'b0, '0),
            sym_row(8'h5a, 1'b1, 1'b1, 32'h0000_0000),
            // unit generator: a lone byte is copied into every check byte
            cfg_row(CFG_GEN_COEFFS, 64'h0101_0101_0101_0101),
            sym_row(8'hff, 1'b1, 1'b1, 32'hffff_ffff),
            sym_row(8'h80, 1'b1, 1'b1, 32'h8080_8080),
            // standard generator, junk in the unused upper bytes
            cfg_row(CFG_GEN_COEFFS, 64'hdead_beef_4078_360f),
            sym_row(8'h01, 1'b1, 1'b1, 32'h0f36_7840),
            sym_row(8'h00, 1'b0, 1'b0, '0),
            sym_row(8'hff, 1'b0, 1'b0, '0),
            sym_row(8'h7f, 1'b0, 1'b0, '0),
            sym_row(8'h80, 1'b1, 1'b0, '0),
            // degenerate reduction polynomial, then a register change mid-codeword
            cfg_row(CFG_FIELD_POLY, 64'h00),
            sym_row(8'hff, 1'b0, 1'b0, '0),
            cfg_row(CFG_GEN_COEFFS, 64'hffff_ffff_ffff_ffff),
            sym_row(8'hc3, 1'b1, 1'b0, '0),
            cfg_row(CFG_FIELD_POLY, 64'hff),
            sym_row(8'hff, 1'b0, 1'b0, '0),
            sym_row(8'h80, 1'b1, 1'b0, '0),
            sym_row(8'h55, 1'b0, 1'b0, '0),
            sym_row(8'haa, 1'b1, 1'b0, '0),
            cfg_row(CFG_FIELD_POLY, 64'(FIELD_POLY_RST))
        };

        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        poly_model = FIELD_POLY_RST;
        gen_model  = GEN_COEFFS_RST;
        foreach (rem_model[i]) rem_model[i] = '0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_CFG) begin
                drain();
                write_reg(rows[r].addr, rows[r].value);
            end else begin
                send_symbol(rows[r].data, rows[r].last, !rows[r].typed);
                if (rows[r].typed && rows[r].last) begin
                    for (int k = 0; k < NCHK; k++) begin
                        beat.symbol = rows[r].checks[SYM_W*(NCHK-1-k) +: SYM_W];
                        beat.index  = IDX_W'(k);
                        beat.last   = (k == NCHK - 1);
                        pending_checks.push_back(beat);
                    end
                end
            end
        end

        // random codewords under each idling pattern; the last phase holds the
        // result side off so the encoder backs up into its input
        for (int ph = 0; ph < 5; ph++) begin
            drain();
            case (ph)
                0: begin send_gap_pct = 0;  stall_pct = 0;  end
                1: begin send_gap_pct = 82; stall_pct = 0;  end
                2: begin send_gap_pct = 0;  stall_pct = 82; end
                3: begin send_gap_pct = 31; stall_pct = 31; end
                default: begin send_gap_pct = 0; stall_pct = 0; end
            endcase
            case ($urandom_range(5))
                0: poly_pick = 8'h00;
                1: poly_pick = 8'hff;
                2: poly_pick = FIELD_POLY_RST;
                3: poly_pick = 8'h2b;
                default: poly_pick = SYM_W'($urandom);
            endcase
            case ($urandom_range(4))
                0: gen_pick = '0;
                1: gen_pick = '1;
                default: gen_pick = {$urandom, $urandom};
            endcase
            write_reg(CFG_FIELD_POLY, 64'(poly_pick));
            write_reg(CFG_GEN_COEFFS, gen_pick);
            if (ph == 4) hold_req = 1'b1;

            // sometimes leave the phase's last codeword open across the next writes
            open_end = ($urandom_range(2) == 0);
            sent = 0;
            while (sent < 20) begin
                cw_len = ($urandom_range(3) == 0) ? 1 : $urandom_range(2, 8);
                for (int k = 0; k < cw_len; k++) begin
                    if ($urandom_range(4) == 0)
                        d = $urandom_range(1) ? 8'hff : 8'h00;
                    else
                        d = SYM_W'($urandom);
                    send_symbol(d, (k == cw_len - 1) && !(open_end && sent + cw_len >= 20),
                                1'b1);
                end
                sent += cw_len;
            end
        end
        drain();

        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/rse_pkg.sv
rtl/rse_lfsr.sv
rtl/rse_unload.sv
rtl/rs_systematic_encoder.sv
dv/tb.sv
